// ===== rtl/lcdts_pkg.sv =====
package lcdts_pkg;

  // saturation limits and rounding
  localparam logic [18:0] MAX_SET_TIME = 19'd359999;
  localparam logic [18:0] MAX_REL_TIME = 19'd359940;
  localparam logic [18:0] ROUND_UP_SEC = 19'd59;
  localparam logic [13:0] MAX_SPEED    = 14'd9999;

  // reciprocal constants: q = (v * K) >> S, exact over the value ranges used here
  localparam logic [19:0] DIV60_SEC_K  = 20'd559241;  // seconds to minutes, v < 2^19
  localparam int          DIV60_SEC_S  = 25;
  localparam logic [13:0] DIV60_MIN_K  = 14'd8739;    // minutes to hours, v < 2^13
  localparam int          DIV60_MIN_S  = 19;
  localparam logic [13:0] DIV100_K     = 14'd10486;   // rpm to hundreds, v < 2^14
  localparam int          DIV100_S     = 20;
  localparam logic [6:0]  DIV10_K      = 7'd103;      // tens of a value below 100
  localparam int          DIV10_S      = 10;

  // segment patterns and merged bits
  localparam logic [7:0] DASH_LOW  = 8'h08;
  localparam logic [7:0] DASH_HIGH = 8'h10;
  localparam logic [7:0] HIGH_BIT  = 8'h80;
  localparam logic [7:0] LOW_BIT   = 8'h01;
  localparam logic [7:0] CLEAR_LOW = 8'hFE;

  localparam int          NUM_WRITES = 16;
  localparam logic [3:0]  LAST_INDEX = 4'd15;

  // decoded refresh handed to the segment formatter
  typedef struct packed {
    logic [6:0] st_hr;
    logic [6:0] st_mn;
    logic [6:0] rt_hr;
    logic [6:0] rt_mn;
    logic [6:0] ss_hi;
    logic [6:0] ss_lo;
    logic [6:0] rs_hi;
    logic [6:0] rs_lo;
    logic       st_zero;
    logic       rt_dash;
    logic       time_blank;
    logic       speed_blank;
    logic       time_icon_off;
    logic       speed_icon_hide;
  } vals_t;

  // sixteen segment bytes in write order
  typedef logic [NUM_WRITES-1:0][7:0] bytes_t;

  // lcd address of each write slot
  function automatic logic [5:0] write_addr(input logic [3:0] idx);
    logic [5:0] a;
    unique case (idx)
      4'd0:  a = 6'd0;
      4'd1:  a = 6'd2;
      4'd2:  a = 6'd4;
      4'd3:  a = 6'd6;
      4'd4:  a = 6'd54;
      4'd5:  a = 6'd52;
      4'd6:  a = 6'd50;
      4'd7:  a = 6'd48;
      4'd8:  a = 6'd26;
      4'd9:  a = 6'd28;
      4'd10: a = 6'd30;
      4'd11: a = 6'd32;
      4'd12: a = 6'd46;
      4'd13: a = 6'd44;
      4'd14: a = 6'd42;
      4'd15: a = 6'd40;
    endcase
    return a;
  endfunction

  // segment table of the set time group
  function automatic logic [7:0] seg_set_time(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h77;
      4'd1:    s = 8'h24;
      4'd2:    s = 8'h5d;
      4'd3:    s = 8'h6d;
      4'd4:    s = 8'h2e;
      4'd5:    s = 8'h6b;
      4'd6:    s = 8'h7b;
      4'd7:    s = 8'h25;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // segment table of the elapsed time and actual speed groups
  function automatic logic [7:0] seg_upper(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hee;
      4'd1:    s = 8'h24;
      4'd2:    s = 8'hba;
      4'd3:    s = 8'hb6;
      4'd4:    s = 8'h74;
      4'd5:    s = 8'hd6;
      4'd6:    s = 8'hde;
      4'd7:    s = 8'ha4;
      4'd8:    s = 8'hfe;
      4'd9:    s = 8'hf6;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // segment table of the set speed group
  function automatic logic [7:0] seg_set_speed(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hee;
      4'd1:    s = 8'h48;
      4'd2:    s = 8'hba;
      4'd3:    s = 8'hda;
      4'd4:    s = 8'h5c;
      4'd5:    s = 8'hd6;
      4'd6:    s = 8'hf6;
      4'd7:    s = 8'h4a;
      4'd8:    s = 8'hfe;
      4'd9:    s = 8'hde;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/lcdts_format.sv =====
module lcdts_format (
  input  lcdts_pkg::vals_t  vals,
  output lcdts_pkg::bytes_t seg_bytes
);
  import lcdts_pkg::*;

  // split a value below 100 into {tens, ones}
  function automatic logic [7:0] split10(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 14'(v) * 14'(DIV10_K);
    tens = 4'(prod >> DIV10_S);
    ones = v - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
    return {tens, ones[3:0]};
  endfunction

  logic [7:0] st_h, st_m, rt_h, rt_m, ss_h, ss_l, rs_h, rs_l;
  logic [7:0] st_seg [4];
  logic [7:0] rt_seg [4];
  logic [7:0] ss_seg [4];
  logic [7:0] rs_seg [4];

  // digit pairs
  always_comb begin
    st_h = split10(vals.st_hr);
    st_m = split10(vals.st_mn);
    rt_h = split10(vals.rt_hr);
    rt_m = split10(vals.rt_mn);
    ss_h = split10(vals.ss_hi);
    ss_l = split10(vals.ss_lo);
    rs_h = split10(vals.rs_hi);
    rs_l = split10(vals.rs_lo);
  end

  // set time: blank, dashes or digits, colon and min bits always on
  always_comb begin
    if (vals.time_blank) begin
      for (int i = 0; i < 4; i++) st_seg[i] = 8'h00;
    end else if (vals.st_zero) begin
      for (int i = 0; i < 4; i++) st_seg[i] = DASH_LOW;
    end else begin
      st_seg[0] = seg_set_time(st_h[7:4]);
      st_seg[1] = seg_set_time(st_h[3:0]);
      st_seg[2] = seg_set_time(st_m[7:4]);
      st_seg[3] = seg_set_time(st_m[3:0]);
    end
    st_seg[1] = st_seg[1] | HIGH_BIT;
    st_seg[3] = st_seg[3] | HIGH_BIT;
  end

  // elapsed time: dashes or digits, colon and icon bits
  always_comb begin
    if (vals.rt_dash) begin
      for (int i = 0; i < 4; i++) rt_seg[i] = DASH_HIGH;
    end else begin
      rt_seg[0] = seg_upper(rt_h[7:4]);
      rt_seg[1] = seg_upper(rt_h[3:0]);
      rt_seg[2] = seg_upper(rt_m[7:4]);
      rt_seg[3] = seg_upper(rt_m[3:0]);
    end
    rt_seg[1] = rt_seg[1] | LOW_BIT;
    rt_seg[3] = rt_seg[3] | LOW_BIT;
    if (vals.time_icon_off) begin
      rt_seg[1] = rt_seg[1] & CLEAR_LOW;
      rt_seg[3] = rt_seg[3] & CLEAR_LOW;
    end
  end

  // set speed: blank or digits, rpm bit on the last digit
  always_comb begin
    if (vals.speed_blank) begin
      for (int i = 0; i < 4; i++) ss_seg[i] = 8'h00;
    end else begin
      ss_seg[0] = seg_set_speed(ss_h[7:4]);
      ss_seg[1] = seg_set_speed(ss_h[3:0]);
      ss_seg[2] = seg_set_speed(ss_l[7:4]);
      ss_seg[3] = seg_set_speed(ss_l[3:0]);
    end
    ss_seg[3] = ss_seg[3] | LOW_BIT;
  end

  // actual speed: digits with rotation icon bits
  always_comb begin
    rs_seg[0] = seg_upper(rs_h[7:4]) | LOW_BIT;
    rs_seg[1] = seg_upper(rs_h[3:0]);
    rs_seg[2] = seg_upper(rs_l[7:4]) | LOW_BIT;
    rs_seg[3] = seg_upper(rs_l[3:0]);
    if (vals.speed_icon_hide) begin
      rs_seg[0] = rs_seg[0] & CLEAR_LOW;
      rs_seg[1] = rs_seg[1] & CLEAR_LOW;
      rs_seg[2] = rs_seg[2] & CLEAR_LOW;
    end
  end

  // bytes in write order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      seg_bytes[i]      = st_seg[i];
      seg_bytes[4 + i]  = rt_seg[i];
      seg_bytes[8 + i]  = ss_seg[i];
      seg_bytes[12 + i] = rs_seg[i];
    end
  end

endmodule

// ===== rtl/lcd_time_speed_segment_formatter_core.sv =====
// LCD time and speed segment formatter. Each refresh beat taken on the item
// channel (set and elapsed time in seconds, set and actual speed in rpm, blink
// and icon flags) yields sixteen write beats of lcd_address and segment_data,
// with last_write on the sixteenth: set time at 0,2,4,6, elapsed time at
// 54,52,50,48, set speed at 26,28,30,32, actual speed at 46,44,42,40. Inputs
// beyond range saturate (times at 99:59, speeds at 9999); elapsed time is
// rounded up to the next minute. A refresh is taken into stage 0 and passes
// through stages 1 and 2 and a sixteen byte write buffer to the registered
// write outputs. The single write port drains the buffer one byte per cycle
// while write_ready is held; the next refresh is taken and decoded while the
// current buffer drains, so writes flow without gaps.
module lcd_time_speed_segment_formatter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [18:0] set_time,
  input  logic [18:0] rel_time,
  input  logic [13:0] set_speed,
  input  logic [13:0] rel_speed,
  input  logic        time_blank,
  input  logic        speed_blank,
  input  logic        time_icon_hide,
  input  logic        speed_icon_hide,
  input  logic        running,
  output logic        write_valid,
  input  logic        write_ready,
  output logic [5:0]  lcd_address,
  output logic [7:0]  segment_data,
  output logic        last_write
);
  import lcdts_pkg::*;

  // stage 0: input register
  logic        v0;
  logic [18:0] s0_set_time, s0_rel_time;
  logic [13:0] s0_set_speed, s0_rel_speed;
  logic        s0_time_blank, s0_speed_blank, s0_time_icon_hide;
  logic        s0_speed_icon_hide, s0_running;

  // stage 1: total minutes and speed hundreds
  logic        v1;
  logic [12:0] s1_st_mt, s1_rt_mt;
  logic [13:0] s1_ss, s1_rs;
  logic [6:0]  s1_ss_hi, s1_rs_hi;
  logic        s1_st_zero, s1_rt_dash, s1_time_blank, s1_speed_blank;
  logic        s1_time_icon_off, s1_speed_icon_hide;

  // stage 2: hour, minute and speed pairs
  logic        v2;
  vals_t       s2_vals;

  // write buffer
  logic        buf_valid;
  logic [3:0]  buf_idx;
  bytes_t      buf_data;
  bytes_t      fmt_bytes;

  // handshake chain
  logic out_free, move, buf_done, ld_buf, s2_open, ld2, s1_open, ld1;

  always_comb begin
    out_free   = !write_valid || write_ready;
    move       = buf_valid && out_free;
    buf_done   = move && (buf_idx == LAST_INDEX);
    ld_buf     = v2 && (!buf_valid || buf_done);
    s2_open    = !v2 || ld_buf;
    ld2        = v1 && s2_open;
    s1_open    = !v1 || ld2;
    ld1        = v0 && s1_open;
    item_ready = !v0 || ld1;
  end

  // stage 0 to 1: saturate, round up, divide seconds by 60 and rpm by 100
  logic [18:0] st_sat, rt_sat, rt_shown;
  logic [13:0] ss_sat, rs_sat;
  logic [38:0] st_prod, rt_prod;
  logic [27:0] ss_prod, rs_prod;

  always_comb begin
    st_sat   = (s0_set_time > MAX_SET_TIME) ? MAX_SET_TIME : s0_set_time;
    rt_sat   = (s0_rel_time > MAX_REL_TIME) ? MAX_REL_TIME : s0_rel_time;
    ss_sat   = (s0_set_speed > MAX_SPEED) ? MAX_SPEED : s0_set_speed;
    rs_sat   = (s0_rel_speed > MAX_SPEED) ? MAX_SPEED : s0_rel_speed;
    rt_shown = rt_sat + ROUND_UP_SEC;
    st_prod  = 39'(st_sat) * 39'(DIV60_SEC_K);
    rt_prod  = 39'(rt_shown) * 39'(DIV60_SEC_K);
    ss_prod  = 28'(ss_sat) * 28'(DIV100_K);
    rs_prod  = 28'(rs_sat) * 28'(DIV100_K);
  end

  // stage 1 to 2: minutes to hours and remainder, speed low pairs
  logic [26:0] st_hprod, rt_hprod;
  logic [6:0]  st_hr, rt_hr;
  logic [12:0] st_mn, rt_mn;
  logic [13:0] ss_lo, rs_lo;

  always_comb begin
    st_hprod = 27'(s1_st_mt) * 27'(DIV60_MIN_K);
    rt_hprod = 27'(s1_rt_mt) * 27'(DIV60_MIN_K);
    st_hr    = 7'(st_hprod >> DIV60_MIN_S);
    rt_hr    = 7'(rt_hprod >> DIV60_MIN_S);
    // 60 * h as (h << 6) - (h << 2)
    st_mn    = s1_st_mt - ({6'b0, st_hr} << 6) + ({6'b0, st_hr} << 2);
    rt_mn    = s1_rt_mt - ({6'b0, rt_hr} << 6) + ({6'b0, rt_hr} << 2);
    // 100 * q as (q << 6) + (q << 5) + (q << 2)
    ss_lo    = s1_ss - ({7'b0, s1_ss_hi} << 6) - ({7'b0, s1_ss_hi} << 5)
               - ({7'b0, s1_ss_hi} << 2);
    rs_lo    = s1_rs - ({7'b0, s1_rs_hi} << 6) - ({7'b0, s1_rs_hi} << 5)
               - ({7'b0, s1_rs_hi} << 2);
  end

  // stage 2 to buffer: digits and segment bytes
  lcdts_format u_format (
    .vals      (s2_vals),
    .seg_bytes (fmt_bytes)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      v0          <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      buf_valid   <= 1'b0;
      buf_idx     <= 4'd0;
      write_valid <= 1'b0;
    end else begin
      if (item_ready) v0 <= item_valid;
      if (s1_open) v1 <= v0;
      if (s2_open) v2 <= v1;
      if (ld_buf) begin
        buf_valid <= 1'b1;
        buf_idx   <= 4'd0;
      end else if (move) begin
        if (buf_done) buf_valid <= 1'b0;
        buf_idx <= buf_idx + 4'd1;
      end
      if (move) begin
        write_valid <= 1'b1;
      end else if (write_ready) begin
        write_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s0_set_time        <= set_time;
      s0_rel_time        <= rel_time;
      s0_set_speed       <= set_speed;
      s0_rel_speed       <= rel_speed;
      s0_time_blank      <= time_blank;
      s0_speed_blank     <= speed_blank;
      s0_time_icon_hide  <= time_icon_hide;
      s0_speed_icon_hide <= speed_icon_hide;
      s0_running         <= running;
    end
    if (ld1) begin
      s1_st_mt           <= 13'(st_prod >> DIV60_SEC_S);
      s1_rt_mt           <= 13'(rt_prod >> DIV60_SEC_S);
      s1_ss              <= ss_sat;
      s1_rs              <= rs_sat;
      s1_ss_hi           <= 7'(ss_prod >> DIV100_S);
      s1_rs_hi           <= 7'(rs_prod >> DIV100_S);
      s1_st_zero         <= (st_sat == 19'd0);
      s1_rt_dash         <= (st_sat == 19'd0) && (rt_sat == 19'd0);
      s1_time_blank      <= s0_time_blank;
      s1_speed_blank     <= s0_speed_blank;
      s1_time_icon_off   <= s0_running && s0_time_icon_hide;
      s1_speed_icon_hide <= s0_speed_icon_hide;
    end
    if (ld2) begin
      s2_vals.st_hr           <= st_hr;
      s2_vals.st_mn           <= st_mn[6:0];
      s2_vals.rt_hr           <= rt_hr;
      s2_vals.rt_mn           <= rt_mn[6:0];
      s2_vals.ss_hi           <= s1_ss_hi;
      s2_vals.ss_lo           <= ss_lo[6:0];
      s2_vals.rs_hi           <= s1_rs_hi;
      s2_vals.rs_lo           <= rs_lo[6:0];
      s2_vals.st_zero         <= s1_st_zero;
      s2_vals.rt_dash         <= s1_rt_dash;
      s2_vals.time_blank      <= s1_time_blank;
      s2_vals.speed_blank     <= s1_speed_blank;
      s2_vals.time_icon_off   <= s1_time_icon_off;
      s2_vals.speed_icon_hide <= s1_speed_icon_hide;
    end
    if (ld_buf) begin
      buf_data <= fmt_bytes;
    end
    if (move) begin
      lcd_address  <= write_addr(buf_idx);
      segment_data <= buf_data[buf_idx];
      last_write   <= (buf_idx == LAST_INDEX);
    end
  end

endmodule

// ===== verif/lcd_time_speed_segment_formatter_core_test.sv =====
`timescale 1ns / 1ps

module lcd_time_speed_segment_formatter_core_test;
  import lcdts_pkg::*;

  localparam int RANDOM_REFRESHES = 320;
  localparam int QUIET_LIMIT      = 3000;
  localparam int DRAIN_CYCLES     = 40;
  // long receiver hold-off so the write buffer fills and the item side stalls
  localparam int HOLD_AT_WRITE    = 900;
  localparam int HOLD_CYCLES      = 300;
  // stretches without any idling on either side
  localparam int SEND_BURST_LO    = 110;
  localparam int SEND_BURST_HI    = 170;
  localparam int RECV_BURST_LO    = 1700;
  localparam int RECV_BURST_HI    = 2700;

  // segment tables, digit 9 first so that index equals digit
  localparam logic [9:0][7:0] SET_TIME_SEG = {
    8'h6f, 8'h7f, 8'h25, 8'h7b, 8'h6b, 8'h2e, 8'h6d, 8'h5d, 8'h24, 8'h77};
  localparam logic [9:0][7:0] UPPER_SEG = {
    8'hf6, 8'hfe, 8'ha4, 8'hde, 8'hd6, 8'h74, 8'hb6, 8'hba, 8'h24, 8'hee};
  localparam logic [9:0][7:0] SET_SPEED_SEG = {
    8'hde, 8'hfe, 8'h4a, 8'hf6, 8'hd6, 8'h5c, 8'hda, 8'hba, 8'h48, 8'hee};
  // lcd address per write slot, slot 15 first
  localparam logic [15:0][5:0] SLOT_ADDR = {
    6'd40, 6'd42, 6'd44, 6'd46, 6'd32, 6'd30, 6'd28, 6'd26,
    6'd48, 6'd50, 6'd52, 6'd54, 6'd6, 6'd4, 6'd2, 6'd0};

  typedef logic [3:0][3:0] digits_t;

  typedef struct packed {
    logic [18:0] set_time;
    logic [18:0] rel_time;
    logic [13:0] set_speed;
    logic [13:0] rel_speed;
    logic        time_blank;
    logic        speed_blank;
    logic        time_icon_hide;
    logic        speed_icon_hide;
    logic        running;
  } refresh_t;

  typedef struct packed {
    logic [5:0] lcd_address;
    logic [7:0] segment_data;
    logic       last_write;
  } lcd_write_t;

  class lcd_write_scoreboard;
    lcd_write_t expected_writes[$];
    int         errors = 0;

    // hh:mm digits, tens of hours first
    function digits_t hhmm_digits(int unsigned secs);
      int unsigned hrs;
      int unsigned mins;
      digits_t d;
      hrs  = secs / 3600;
      mins = (secs % 3600) / 60;
      d[0] = 4'((hrs / 10) % 10);
      d[1] = 4'(hrs % 10);
      d[2] = 4'((mins / 10) % 10);
      d[3] = 4'(mins % 10);
      return d;
    endfunction

    // four rpm digits, thousands first
    function digits_t rpm_digits(int unsigned rpm);
      digits_t d;
      d[0] = 4'((rpm / 1000) % 10);
      d[1] = 4'((rpm / 100) % 10);
      d[2] = 4'((rpm / 10) % 10);
      d[3] = 4'(rpm % 10);
      return d;
    endfunction

    // predict the sixteen writes of one accepted refresh
    function void note_refresh(refresh_t r);
      int unsigned st, rt, ss, rs;
      digits_t d;
      logic [15:0][7:0] seg;
      lcd_write_t w;
      st = 32'((r.set_time > MAX_SET_TIME) ? MAX_SET_TIME : r.set_time);
      rt = 32'((r.rel_time > MAX_REL_TIME) ? MAX_REL_TIME : r.rel_time);
      ss = 32'((r.set_speed > MAX_SPEED) ? MAX_SPEED : r.set_speed);
      rs = 32'((r.rel_speed > MAX_SPEED) ? MAX_SPEED : r.rel_speed);

      // set time: digits, dashes when zero, blank during blink
      d = hhmm_digits(st);
      for (int i = 0; i < 4; i++) begin
        if (r.time_blank) seg[i] = 8'h00;
        else if (st != 0) seg[i] = SET_TIME_SEG[d[i]];
        else seg[i] = DASH_LOW;
      end
      seg[1] |= HIGH_BIT;
      seg[3] |= HIGH_BIT;

      // elapsed time rounded up to the next minute
      d = hhmm_digits(rt + 59);
      for (int i = 0; i < 4; i++) begin
        seg[4+i] = (rt != 0 || st != 0) ? UPPER_SEG[d[i]] : DASH_HIGH;
      end
      seg[5] |= LOW_BIT;
      seg[7] |= LOW_BIT;
      if (r.running && r.time_icon_hide) begin
        seg[5] &= CLEAR_LOW;
        seg[7] &= CLEAR_LOW;
      end

      // set speed with rpm unit bit
      d = rpm_digits(ss);
      for (int i = 0; i < 4; i++) begin
        seg[8+i] = r.speed_blank ? 8'h00 : SET_SPEED_SEG[d[i]];
      end
      seg[11] |= LOW_BIT;

      // actual speed with rotation icon bits
      d = rpm_digits(rs);
      for (int i = 0; i < 4; i++) seg[12+i] = UPPER_SEG[d[i]];
      seg[12] |= LOW_BIT;
      seg[14] |= LOW_BIT;
      if (r.speed_icon_hide) begin
        seg[12] &= CLEAR_LOW;
        seg[13] &= CLEAR_LOW;
        seg[14] &= CLEAR_LOW;
      end

      for (int k = 0; k < 16; k++) begin
        w.lcd_address  = SLOT_ADDR[k];
        w.segment_data = seg[k];
        w.last_write   = (k == 15);
        expected_writes.push_back(w);
      end
    endfunction

    // compare one accepted write beat with the oldest prediction
    function void check_write(lcd_write_t got);
      lcd_write_t exp_w;
      if (expected_writes.size() == 0) begin
        $error("write beat with nothing expected: lcd_address %0d segment_data %h",
               got.lcd_address, got.segment_data);
        errors++;
        return;
      end
      exp_w = expected_writes.pop_front();
      if (got.lcd_address !== exp_w.lcd_address) begin
        $error("lcd_address expected %0d actual %0d", exp_w.lcd_address, got.lcd_address);
        errors++;
      end
      if (got.segment_data !== exp_w.segment_data) begin
        $error("segment_data expected %h actual %h", exp_w.segment_data, got.segment_data);
        errors++;
      end
      if (got.last_write !== exp_w.last_write) begin
        $error("last_write expected %0b actual %0b", exp_w.last_write, got.last_write);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [18:0] set_time = '0;
  logic [18:0] rel_time = '0;
  logic [13:0] set_speed = '0;
  logic [13:0] rel_speed = '0;
  logic        time_blank = 1'b0;
  logic        speed_blank = 1'b0;
  logic        time_icon_hide = 1'b0;
  logic        speed_icon_hide = 1'b0;
  logic        running = 1'b0;
  logic        write_valid;
  logic        write_ready = 1'b0;
  logic [5:0]  lcd_address;
  logic [7:0]  segment_data;
  logic        last_write;

  lcd_write_scoreboard sb = new();
  int refreshes_sent = 0;
  int writes_seen = 0;
  int quiet_cycles = 0;

  lcd_time_speed_segment_formatter_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // offer one refresh after a random gap, none in the send burst, and wait for its beat
  task automatic send_refresh(input refresh_t r);
    int gap;
    gap = (refreshes_sent >= SEND_BURST_LO && refreshes_sent < SEND_BURST_HI) ?
          0 : $urandom_range(0, 8);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    set_time        <= r.set_time;
    rel_time        <= r.rel_time;
    set_speed       <= r.set_speed;
    rel_speed       <= r.rel_speed;
    time_blank      <= r.time_blank;
    speed_blank     <= r.speed_blank;
    time_icon_hide  <= r.time_icon_hide;
    speed_icon_hide <= r.speed_icon_hide;
    running         <= r.running;
    item_valid      <= 1'b1;
    do @(posedge clk); while (!item_ready);
    sb.note_refresh(r);
    refreshes_sent++;
  endtask

  // flags packed as time_blank, speed_blank, time_icon_hide, speed_icon_hide, running
  task automatic send_fields(input logic [18:0] st, input logic [18:0] rt,
                             input logic [13:0] ss, input logic [13:0] rs,
                             input logic [4:0] flags);
    refresh_t r;
    r = {st, rt, ss, rs, flags};
    send_refresh(r);
  endtask

  function automatic refresh_t random_refresh();
    refresh_t r;
    int kind;
    kind = $urandom_range(0, 99);
    r.time_blank      = ($urandom_range(0, 3) == 0);
    r.speed_blank     = ($urandom_range(0, 3) == 0);
    r.time_icon_hide  = 1'($urandom_range(0, 1));
    r.speed_icon_hide = 1'($urandom_range(0, 1));
    r.running         = 1'($urandom_range(0, 1));
    if (kind < 12) begin
      // full width, partly beyond range
      r.set_time  = 19'($urandom_range(0, 19'h7ffff));
      r.rel_time  = 19'($urandom_range(0, 19'h7ffff));
      r.set_speed = 14'($urandom_range(0, 14'h3fff));
      r.rel_speed = 14'($urandom_range(0, 14'h3fff));
    end else begin
      r.set_time  = (kind < 22) ? 19'd0 : 19'($urandom_range(1, 359999));
      r.rel_time  = (kind < 17 || kind > 90) ? 19'd0 : 19'($urandom_range(0, 359940));
      r.set_speed = 14'($urandom_range(0, 9999));
      r.rel_speed = 14'($urandom_range(0, 9999));
    end
    return r;
  endfunction

  // stimulus and end of run
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: dashes, blanking, icons, rounding, extremes
    send_fields(19'd0, 19'd0, 14'd0, 14'd0, 5'b00000);
    send_fields(19'd0, 19'd1, 14'd1234, 14'd5678, 5'b00000);
    send_fields(19'd60, 19'd0, 14'd9012, 14'd3456, 5'b00000);
    send_fields(19'd359999, 19'd359940, 14'd9999, 14'd9999, 5'b00000);
    send_fields(19'h7ffff, 19'h7ffff, 14'h3fff, 14'h3fff, 5'b11111);
    send_fields(19'd360000, 19'd359941, 14'd10000, 14'd10000, 5'b00000);
    send_fields(19'd0, 19'd0, 14'd7890, 14'd1, 5'b10000);
    send_fields(19'd45296, 19'd3541, 14'd4321, 14'd9876, 5'b10000);
    send_fields(19'd3599, 19'd60, 14'd5555, 14'd2468, 5'b01000);
    send_fields(19'd7200, 19'd3600, 14'd0, 14'd1357, 5'b00101);
    send_fields(19'd7200, 19'd3600, 14'd100, 14'd1357, 5'b00001);
    send_fields(19'd7200, 19'd3600, 14'd10, 14'd1357, 5'b00100);
    send_fields(19'd1, 19'd59, 14'd2000, 14'd8080, 5'b00010);
    send_fields(19'd86399, 19'd86340, 14'd6543, 14'd7777, 5'b00011);
    send_fields(19'd0, 19'd359940, 14'd9999, 14'd0, 5'b11101);
    send_fields(19'd123456, 19'd0, 14'd8642, 14'd10, 5'b01010);
    send_fields(19'd0, 19'd0, 14'd0, 14'd0, 5'b11111);

    for (int n = 0; n < RANDOM_REFRESHES; n++) send_refresh(random_refresh());
    item_valid <= 1'b0;

    while (sb.expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_writes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // write side with random stalls, one long hold-off and a burst stretch
  initial begin : write_sink
    int stall;
    lcd_write_t got;
    while (rst) @(posedge clk);
    forever begin
      if (writes_seen == HOLD_AT_WRITE) stall = HOLD_CYCLES;
      else if (writes_seen >= RECV_BURST_LO && writes_seen < RECV_BURST_HI) stall = 0;
      else stall = $urandom_range(0, 8);
      if (stall > 0) begin
        write_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      write_ready <= 1'b1;
      do @(posedge clk); while (!write_valid);
      got.lcd_address  = lcd_address;
      got.segment_data = segment_data;
      got.last_write   = last_write;
      sb.check_write(got);
      writes_seen++;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && item_ready) || (write_valid && write_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// ===== lcd_time_speed_segment_formatter_core.f =====
rtl/lcdts_pkg.sv
rtl/lcdts_format.sv
rtl/lcd_time_speed_segment_formatter_core.sv
verif/lcd_time_speed_segment_formatter_core_test.sv
